/* rtl/ilist_pkg.sv */
// Shared constants and types for the indexed list block.
// No dependencies; imported by indexed_list_with_shift_top.
package ilist_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int POS_W       = 5;
    localparam int REQ_W       = 3;
    localparam int STAT_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 3'd0,
        REQ_INSERT    = 3'd1,
        REQ_OVERWRITE = 3'd2,
        REQ_DELETE    = 3'd3,
        REQ_READ      = 3'd4,
        REQ_FIND      = 3'd5
    } t_req_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SHIFT,
        S_INS_LAST,
        S_RD_WAIT,
        S_CMP,
        S_DONE
    } t_state_e;

endpackage

/* rtl/indexed_list_with_shift_top.sv */
// Top level of the indexed list: entry memory, sequencer and result register.
// Depends on ilist_pkg.
//
// The block keeps an ordered list of up to 16 values in a one-write, one-read
// memory with registered read data, and handles one request at a time.
// Append, overwrite, an insert at the end of the list, a delete of the last entry,
// every rejected request and the unused codes finish in the start state; read waits
// for the registered read data. Insert moves the entries from the end of the list up
// by one, down to the position, and then writes the new value there; delete moves
// the entries above the position down by one; find compares the entries from the
// first on until one matches or the list ends. Each shifted or compared entry passes
// through the single memory port pair. The input is stalled until the result has
// been moved into the output register, which then holds it until it is taken.
module indexed_list_with_shift_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ilist_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ilist_pkg::REQ_W-1:0]       i_req_type,
    input  logic [ilist_pkg::POS_W-1:0]       i_position,
    input  logic [ilist_pkg::DATA_W-1:0]      i_element_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ilist_pkg::STAT_W-1:0]      o_status,
    output logic [ilist_pkg::DATA_W-1:0]      o_read_value,
    output logic                              o_found,
    output logic [ilist_pkg::IDX_W-1:0]       o_found_position,
    output logic [ilist_pkg::CNT_W-1:0]       o_entry_count,
    output logic                              o_list_full
);
    import ilist_pkg::*;

    t_state_e               r_state, n_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [REQ_W-1:0]       r_req;
    logic [POS_W-1:0]       r_pos;
    logic [DATA_W-1:0]      r_val;
    logic [STAT_W-1:0]      r_status, n_status;
    logic [DATA_W-1:0]      r_res_value, n_res_value;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_fpos, n_fpos;

    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_o_status;
    logic [DATA_W-1:0]      r_o_value;
    logic                   r_o_found;
    logic [IDX_W-1:0]       r_o_fpos;
    logic [CNT_W-1:0]       r_o_count;
    logic                   r_o_full;

    logic [DATA_W-1:0]      r_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]      r_rd_data;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;

    logic [CNT_W-1:0]       cap_now;
    logic                   list_full;
    logic                   in_xfer;
    logic                   out_free;
    logic [CNT_W-1:0]       pos_ext;
    logic [CNT_W-1:0]       idx_ext;

    always_comb begin
        if (r_cap == '0) begin
            cap_now = CNT_W'(1);
        end else if (r_cap > CAP_W'(MAX_ENTRIES)) begin
            cap_now = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_now = CNT_W'(r_cap);
        end
    end

    assign list_full = (r_count >= cap_now);
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign pos_ext   = CNT_W'(r_pos);
    assign idx_ext   = CNT_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_W'(MAX_ENTRIES);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_res_value <= n_res_value;
        r_found     <= n_found;
        r_fpos      <= n_fpos;
        if (in_xfer) begin
            r_req <= i_req_type;
            r_pos <= i_position;
            r_val <= i_element_value;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_value  <= r_res_value;
            r_o_found  <= r_found;
            r_o_fpos   <= r_fpos;
            r_o_count  <= r_count;
            r_o_full   <= list_full;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_status    = r_status;
        n_res_value = r_res_value;
        n_found     = r_found;
        n_fpos      = r_fpos;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rd_data;
        mem_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_status    = ST_OK;
                    n_res_value = '0;
                    n_found     = 1'b0;
                    n_fpos      = '0;
                    n_state     = S_START;
                end
            end
            S_START: begin
                n_state = S_DONE;
                case (r_req)
                    REQ_APPEND: begin
                        if (list_full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[IDX_W-1:0];
                            mem_wdata = r_val;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    REQ_INSERT: begin
                        if (pos_ext > r_count) begin
                            n_status = ST_BAD_POS;
                        end else if (list_full) begin
                            n_status = ST_FULL;
                        end else if (pos_ext == r_count) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pos[IDX_W-1:0];
                            mem_wdata = r_val;
                            n_count   = r_count + CNT_W'(1);
                        end else begin
                            n_idx     = r_count[IDX_W-1:0];
                            mem_raddr = r_count[IDX_W-1:0] - IDX_W'(1);
                            n_state   = S_SHIFT;
                        end
                    end
                    REQ_OVERWRITE: begin
                        if (pos_ext >= r_count) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pos[IDX_W-1:0];
                            mem_wdata = r_val;
                        end
                    end
                    REQ_DELETE: begin
                        if (pos_ext >= r_count) begin
                            n_status = ST_BAD_POS;
                        end else if (pos_ext + CNT_W'(1) == r_count) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_idx     = r_pos[IDX_W-1:0];
                            mem_raddr = r_pos[IDX_W-1:0] + IDX_W'(1);
                            n_state   = S_SHIFT;
                        end
                    end
                    REQ_READ: begin
                        if (pos_ext >= r_count) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            mem_raddr = r_pos[IDX_W-1:0];
                            n_state   = S_RD_WAIT;
                        end
                    end
                    REQ_FIND: begin
                        if (r_count != '0) begin
                            n_idx     = '0;
                            mem_raddr = '0;
                            n_state   = S_CMP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd_data;
                if (r_req == REQ_INSERT) begin
                    if (idx_ext - CNT_W'(1) == pos_ext) begin
                        n_idx   = r_pos[IDX_W-1:0];
                        n_state = S_INS_LAST;
                    end else begin
                        n_idx     = r_idx - IDX_W'(1);
                        mem_raddr = r_idx - IDX_W'(2);
                    end
                end else begin
                    if (idx_ext + CNT_W'(2) == r_count) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        mem_raddr = r_idx + IDX_W'(2);
                    end
                end
            end
            S_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_DONE;
            end
            S_RD_WAIT: begin
                n_res_value = r_rd_data;
                n_state     = S_DONE;
            end
            S_CMP: begin
                if (r_rd_data == r_val) begin
                    n_found = 1'b1;
                    n_fpos  = r_idx;
                    n_state = S_DONE;
                end else if (idx_ext + CNT_W'(1) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_idx     = r_idx + IDX_W'(1);
                    mem_raddr = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_read_value     = r_o_value;
    assign o_found          = r_o_found;
    assign o_found_position = r_o_fpos;
    assign o_entry_count    = r_o_count;
    assign o_list_full      = r_o_full;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("Input taken while a request was still in progress.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1) || r_count + CNT_W'(1) == $past(r_count)))
        else $error("Entry count moved by more than one.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_count <= CNT_W'(MAX_ENTRIES)))
        else $error("Entry count beyond the list depth.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_list_full)
        else $error("Full status reported on a list that is not full.");

endmodule

/* bench/indexed_list_with_shift_top_tb.sv */
// Self-checking testbench for indexed_list_with_shift_top: a directed pass and random traffic.
// A list predictor inside the bench checks every result; it depends on ilist_pkg and the RTL.
`timescale 1ns / 100ps

module indexed_list_with_shift_top_tb;
    import ilist_pkg::*;

    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 240;
    localparam int MAX_PRINTS   = 40;

    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic [IDX_W-1:0]  found_position;
        logic [CNT_W-1:0]  entry_count;
        logic              list_full;
    } t_list_result;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [CAP_W-1:0]    i_cfg_data      = '0;
    logic                i_in_valid      = 1'b0;
    logic [REQ_W-1:0]    i_req_type      = '0;
    logic [POS_W-1:0]    i_position      = '0;
    logic [DATA_W-1:0]   i_element_value = '0;
    logic                i_out_stall     = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [STAT_W-1:0]   o_status;
    logic [DATA_W-1:0]   o_read_value;
    logic                o_found;
    logic [IDX_W-1:0]    o_found_position;
    logic [CNT_W-1:0]    o_entry_count;
    logic                o_list_full;

    logic [DATA_W-1:0]   model_entries [MAX_ENTRIES];
    int                  model_count = 0;
    logic [CAP_W-1:0]    model_cap   = 5'd16;
    bit                  growing     = 1'b1;

    t_list_result        pending_results [$];
    int                  send_idle_pct  = 0;
    int                  stall_pct      = 0;
    int                  requests_sent  = 0;
    int                  results_seen   = 0;
    int                  error_count    = 0;
    int                  phase_count    = 0;
    int                  cap_writes     = 0;
    int                  full_rejects   = 0;
    int                  bad_positions  = 0;
    int                  find_hits      = 0;

    indexed_list_with_shift_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_element_value  (i_element_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_list_full      (o_list_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int effective_capacity();
        if (model_cap == 0) return 1;
        if (model_cap > MAX_ENTRIES) return MAX_ENTRIES;
        return int'(model_cap);
    endfunction

    function automatic t_list_result apply_request(input logic [REQ_W-1:0] req,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        t_list_result r;
        int cap_eff;
        int p;
        logic at_limit;
        r = '0;
        cap_eff = effective_capacity();
        p = int'(pos);
        at_limit = (model_count >= cap_eff);
        case (req)
            REQ_APPEND: begin
                if (at_limit) begin
                    r.status = ST_FULL;
                end else begin
                    model_entries[model_count] = val;
                    model_count++;
                end
            end
            REQ_INSERT: begin
                if (p > model_count) begin
                    r.status = ST_BAD_POS;
                end else if (at_limit) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = model_count; i > p; i--) model_entries[i] = model_entries[i-1];
                    model_entries[p] = val;
                    model_count++;
                end
            end
            REQ_OVERWRITE: begin
                if (p >= model_count) r.status = ST_BAD_POS;
                else model_entries[p] = val;
            end
            REQ_DELETE: begin
                if (p >= model_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = p; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
                    model_count--;
                end
            end
            REQ_READ: begin
                if (p >= model_count) r.status = ST_BAD_POS;
                else r.read_value = model_entries[p];
            end
            REQ_FIND: begin
                for (int i = 0; i < model_count && !r.found; i++) begin
                    if (model_entries[i] == val) begin
                        r.found = 1'b1;
                        r.found_position = i[IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        if (r.status == ST_FULL) full_rejects++;
        if (r.status == ST_BAD_POS) bad_positions++;
        if (r.found) find_hits++;
        r.entry_count = model_count[CNT_W-1:0];
        r.list_full = (model_count >= cap_eff);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch on result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", o_read_value, want.read_value);
                if (o_found !== want.found)
                    report_mismatch("found", DATA_W'(o_found), DATA_W'(want.found));
                if (o_found_position !== want.found_position)
                    report_mismatch("found_position", DATA_W'(o_found_position),
                                    DATA_W'(want.found_position));
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", DATA_W'(o_entry_count),
                                    DATA_W'(want.entry_count));
                if (o_list_full !== want.list_full)
                    report_mismatch("list_full", DATA_W'(o_list_full), DATA_W'(want.list_full));
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_position      <= pos;
        i_element_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_request(req, pos, val));
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_cap = cap;
        cap_writes++;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return DATA_W'($urandom_range(0, 7));
        if (roll < 45) return '1;
        if (roll < 50) return 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic random_request();
        int unsigned roll;
        int w_app, w_ins, w_del;
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] val;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            req = REQ_W'($urandom);
            pos = POS_W'($urandom);
            val = $urandom;
        end else begin
            if (model_count >= effective_capacity()) growing = 1'b0;
            else if (model_count == 0) growing = 1'b1;
            w_app = growing ? 25 : 8;
            w_ins = w_app + (growing ? 25 : 8);
            w_del = w_ins + (growing ? 10 : 44);
            roll = $urandom_range(0, 99);
            if (roll < w_app) req = REQ_APPEND;
            else if (roll < w_ins) req = REQ_INSERT;
            else if (roll < w_del) req = REQ_DELETE;
            else if (roll < w_del + 12) req = REQ_OVERWRITE;
            else if (roll < w_del + 26) req = REQ_READ;
            else req = REQ_FIND;
            if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom);
            else if (req == REQ_INSERT) pos = POS_W'($urandom_range(0, model_count));
            else if (model_count > 0) pos = POS_W'($urandom_range(0, model_count - 1));
            else pos = '0;
            if (req == REQ_FIND && model_count > 0 && $urandom_range(0, 99) < 60)
                val = model_entries[$urandom_range(0, model_count - 1)];
            else
                val = pick_value();
        end
        send_request(req, pos, val);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                             input int stall_chance);
        write_capacity(cap);
        send_idle_pct = idle_pct;
        stall_pct = stall_chance;
        phase_count++;
        repeat (PHASE_ITEMS) random_request();
    endtask

    task automatic test_directed();
        send_request(REQ_READ, 5'd0, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0);
        send_request(REQ_FIND, 5'd0, 32'h0);
        send_request(REQ_INSERT, 5'd1, 32'h1111_1111);
        send_request(REQ_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 5'd31, 32'h0000_0000);
        send_request(REQ_APPEND, 5'd0, 32'hFFFF_FFFF);
        send_request(REQ_FIND, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 5'd3, 32'h1234_5678);
        send_request(REQ_INSERT, 5'd1, 32'h5A5A_5A5A);
        send_request(REQ_READ, 5'd4, 32'hFFFF_FFFF);
        send_request(REQ_READ, 5'd5, 32'h0);
        send_request(REQ_READ, 5'd31, 32'h0);
        send_request(REQ_OVERWRITE, 5'd0, 32'h0000_0000);
        send_request(REQ_OVERWRITE, 5'd5, 32'hA5A5_A5A5);
        send_request(REQ_FIND, 5'd0, 32'h0000_0000);
        send_request(REQ_DELETE, 5'd4, 32'hFFFF_FFFF);
        send_request(REQ_DELETE, 5'd0, 32'h0);
        send_request(REQ_DELETE, 5'd31, 32'h0);
        send_request(REQ_UNUSED_6, 5'd31, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED_7, 5'd0, 32'hFFFF_FFFF);
        send_request(REQ_READ, 5'd0, 32'h0);
        // Capacity below the count: the list reads as full and a delete of the last entry still works.
        write_capacity(5'd1);
        send_request(REQ_APPEND, 5'd0, 32'h7777_7777);
        send_request(REQ_INSERT, 5'd5, 32'h7777_7777);
        send_request(REQ_INSERT, 5'd0, 32'h7777_7777);
        send_request(REQ_DELETE, 5'd2, 32'h0);
    endtask

    task automatic test_back_to_back();
        run_phase(5'd16, 0, 0);
        run_phase(5'd1, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_phase(5'd0, 56, 0);
        run_phase(5'd31, 56, 0);
    endtask

    task automatic test_receiver_stall();
        run_phase(5'd5, 0, 56);
        run_phase(CAP_W'($urandom_range(1, MAX_ENTRIES)), 0, 56);
    endtask

    task automatic test_both_idle();
        run_phase(5'd2, 22, 22);
        run_phase(5'd16, 22, 22);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stall();
        test_both_idle();
        wait_idle();
        $display("Ran %0d requests (%0d results) over %0d random phases and %0d capacity writes.",
                 requests_sent, results_seen, phase_count, cap_writes);
        $display("Saw %0d full rejections, %0d bad positions, %0d find hits, %0d mismatches.",
                 full_rejects, bad_positions, find_hits, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
